>>> rtl/assert_macros.svh
// Assertion macros used by the checker file.
// Depends on nothing; clock and reset are taken as clk_i and rst_ni.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent property on clk_i, off while rst_ni is low.
`define ASSERT_CLK(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");

// Condition that must never hold at a clock edge.
`define ASSERT_NEVER(lbl, cond) `ASSERT_CLK(lbl, !(cond))

`endif

>>> rtl/prc_pkg.sv
// Package for the point rotation block: widths, register indexes,
// the quarter-wave sine table and its scaling. Depends on nothing.
package prc_pkg;

  localparam int COORD_BITS     = 16;
  localparam int TRIG_FRAC_BITS = 16;
  localparam int ANGLE_BITS     = 10;

  localparam int CFG_W     = (COORD_BITS > ANGLE_BITS) ? COORD_BITS : ANGLE_BITS;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y = 2'd2;

  localparam int DEG_FULL = 360;
  localparam int DEG_W    = 9;   // holds 0..359
  localparam int REM_W    = 7;   // holds 0..90

  localparam int DIFF_W = COORD_BITS + 1;
  localparam int TRIG_W = TRIG_FRAC_BITS + 2;
  localparam int PROD_W = DIFF_W + TRIG_W;
  localparam int SUM_W  = PROD_W + 1;
  localparam int OFF_W  = SUM_W - TRIG_FRAC_BITS;
  localparam int RES_W  = OFF_W + 1;

  localparam logic signed [COORD_BITS-1:0] COORD_HI = COORD_BITS'((2 ** (COORD_BITS - 1)) - 1);
  localparam logic signed [COORD_BITS-1:0] COORD_LO = ~COORD_HI;

  localparam int SH_UP = (TRIG_FRAC_BITS >= 16) ? TRIG_FRAC_BITS - 16 : 0;
  localparam int SH_DN = (TRIG_FRAC_BITS < 16) ? 16 - TRIG_FRAC_BITS : 0;
  localparam longint unsigned TRIG_RND = (SH_DN == 0) ? 0 : (64'd1 << (SH_DN - 1));

  // round(sin(k deg) * 2^16), k = 0..90
  function automatic logic [16:0] sine_q16(input logic [REM_W-1:0] k);
    logic [16:0] v;
    unique case (k)
      7'd0:  v = 17'd0;     7'd1:  v = 17'd1144;  7'd2:  v = 17'd2287;
      7'd3:  v = 17'd3430;  7'd4:  v = 17'd4572;  7'd5:  v = 17'd5712;
      7'd6:  v = 17'd6850;  7'd7:  v = 17'd7987;  7'd8:  v = 17'd9121;
      7'd9:  v = 17'd10252; 7'd10: v = 17'd11380; 7'd11: v = 17'd12505;
      7'd12: v = 17'd13626; 7'd13: v = 17'd14742; 7'd14: v = 17'd15855;
      7'd15: v = 17'd16962; 7'd16: v = 17'd18064; 7'd17: v = 17'd19161;
      7'd18: v = 17'd20252; 7'd19: v = 17'd21336; 7'd20: v = 17'd22415;
      7'd21: v = 17'd23486; 7'd22: v = 17'd24550; 7'd23: v = 17'd25607;
      7'd24: v = 17'd26656; 7'd25: v = 17'd27697; 7'd26: v = 17'd28729;
      7'd27: v = 17'd29753; 7'd28: v = 17'd30767; 7'd29: v = 17'd31772;
      7'd30: v = 17'd32768; 7'd31: v = 17'd33754; 7'd32: v = 17'd34729;
      7'd33: v = 17'd35693; 7'd34: v = 17'd36647; 7'd35: v = 17'd37590;
      7'd36: v = 17'd38521; 7'd37: v = 17'd39441; 7'd38: v = 17'd40348;
      7'd39: v = 17'd41243; 7'd40: v = 17'd42126; 7'd41: v = 17'd42995;
      7'd42: v = 17'd43852; 7'd43: v = 17'd44695; 7'd44: v = 17'd45525;
      7'd45: v = 17'd46341; 7'd46: v = 17'd47143; 7'd47: v = 17'd47930;
      7'd48: v = 17'd48703; 7'd49: v = 17'd49461; 7'd50: v = 17'd50203;
      7'd51: v = 17'd50931; 7'd52: v = 17'd51643; 7'd53: v = 17'd52339;
      7'd54: v = 17'd53020; 7'd55: v = 17'd53684; 7'd56: v = 17'd54332;
      7'd57: v = 17'd54963; 7'd58: v = 17'd55578; 7'd59: v = 17'd56175;
      7'd60: v = 17'd56756; 7'd61: v = 17'd57319; 7'd62: v = 17'd57865;
      7'd63: v = 17'd58393; 7'd64: v = 17'd58903; 7'd65: v = 17'd59396;
      7'd66: v = 17'd59870; 7'd67: v = 17'd60326; 7'd68: v = 17'd60764;
      7'd69: v = 17'd61183; 7'd70: v = 17'd61584; 7'd71: v = 17'd61966;
      7'd72: v = 17'd62328; 7'd73: v = 17'd62672; 7'd74: v = 17'd62997;
      7'd75: v = 17'd63303; 7'd76: v = 17'd63589; 7'd77: v = 17'd63856;
      7'd78: v = 17'd64104; 7'd79: v = 17'd64332; 7'd80: v = 17'd64540;
      7'd81: v = 17'd64729; 7'd82: v = 17'd64898; 7'd83: v = 17'd65048;
      7'd84: v = 17'd65177; 7'd85: v = 17'd65287; 7'd86: v = 17'd65376;
      7'd87: v = 17'd65446; 7'd88: v = 17'd65496; 7'd89: v = 17'd65526;
      default: v = 17'd65536;  // 90 and above clamp to the peak
    endcase
    return v;
  endfunction

  // Table entry brought to Q1.TRIG_FRAC_BITS (rounding half up when narrowing).
  function automatic logic signed [TRIG_W-1:0] trig_scaled(input logic [REM_W-1:0] k);
    logic [63:0] t;
    t = 64'(sine_q16(k));
    if (TRIG_FRAC_BITS >= 16) begin
      t = t << SH_UP;
    end else begin
      t = (t + TRIG_RND) >> SH_DN;
    end
    return signed'(t[TRIG_W-1:0]);
  endfunction

endpackage

>>> rtl/point_rotate_about_center_top.sv
// Point rotation about a configured center by a whole-degree angle.
// Throughput: one word per cycle, set by the five-register datapath; busy low after reset.
// Reset (async, active low): clears all valid bits, angle 0, center (0,0); busy high in reset.
// The receiver cannot stall: each result shows for one cycle with done_o.
// Depends on prc_pkg.
module point_rotate_about_center_top (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start,
  output logic                                  busy,
  input  logic signed [prc_pkg::COORD_BITS-1:0] point_x_i,
  input  logic signed [prc_pkg::COORD_BITS-1:0] point_y_i,
  input  logic                                  cfg_we_i,
  input  logic        [prc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic        [prc_pkg::CFG_W-1:0]      cfg_wdata_i,
  output logic                                  done_o,
  output logic signed [prc_pkg::COORD_BITS-1:0] rotated_x_o,
  output logic signed [prc_pkg::COORD_BITS-1:0] rotated_y_o,
  output logic                                  saturated_o
);
  import prc_pkg::*;

  // ---------------------------------------------------------------
  // Configuration. The angle is reduced to 0..359 on write; sine and
  // cosine are derived from it into registers in the cycle after, which
  // is before any following word reaches the multiplier stage.
  // ---------------------------------------------------------------
  logic        [DEG_W-1:0]      angle_q, angle_d;
  logic signed [COORD_BITS-1:0] cx_q, cy_q;
  logic signed [ANGLE_BITS+1:0] ang_wide;
  logic signed [ANGLE_BITS+1:0] ang_red;

  always_comb begin
    ang_wide = (ANGLE_BITS + 2)'(signed'(cfg_wdata_i[ANGLE_BITS-1:0]));
    // Floored modulo over the 10-bit register range
    priority if (ang_wide >= (ANGLE_BITS + 2)'(DEG_FULL)) begin
      ang_red = ang_wide - (ANGLE_BITS + 2)'(DEG_FULL);
    end else if (ang_wide >= 0) begin
      ang_red = ang_wide;
    end else if (ang_wide >= -(ANGLE_BITS + 2)'(DEG_FULL)) begin
      ang_red = ang_wide + (ANGLE_BITS + 2)'(DEG_FULL);
    end else begin
      ang_red = ang_wide + (ANGLE_BITS + 2)'(2 * DEG_FULL);
    end
    angle_d = ang_red[DEG_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      angle_q <= '0;
      cx_q    <= '0;
      cy_q    <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ANGLE:    angle_q <= angle_d;
        CFG_CENTER_X: cx_q    <= cfg_wdata_i[COORD_BITS-1:0];
        CFG_CENTER_Y: cy_q    <= cfg_wdata_i[COORD_BITS-1:0];
        default: ;  // unused index, dropped
      endcase
    end
  end

  // Quadrant split and table lookup. Quarter turns fall out exactly:
  // the table gives 0 and 1.0 at the ends.
  logic        [DEG_W-1:0]  rem_deg;
  logic        [1:0]        quad;
  logic        [REM_W-1:0]  rem;
  logic signed [TRIG_W-1:0] tab_a, tab_b;
  logic signed [TRIG_W-1:0] sin_d, cos_d, sin_q, cos_q;

  always_comb begin
    priority if (angle_q >= DEG_W'(270)) begin
      quad = 2'd3; rem_deg = angle_q - DEG_W'(270);
    end else if (angle_q >= DEG_W'(180)) begin
      quad = 2'd2; rem_deg = angle_q - DEG_W'(180);
    end else if (angle_q >= DEG_W'(90)) begin
      quad = 2'd1; rem_deg = angle_q - DEG_W'(90);
    end else begin
      quad = 2'd0; rem_deg = angle_q;
    end
    rem   = rem_deg[REM_W-1:0];
    tab_a = trig_scaled(rem);
    tab_b = trig_scaled(REM_W'(90) - rem);
    unique case (quad)
      2'd0: begin sin_d = tab_a;  cos_d = tab_b;  end
      2'd1: begin sin_d = tab_b;  cos_d = -tab_a; end
      2'd2: begin sin_d = -tab_a; cos_d = -tab_b; end
      default: begin sin_d = -tab_b; cos_d = tab_a; end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sin_q <= '0;
      cos_q <= TRIG_W'(1) << TRIG_FRAC_BITS;
    end else begin
      sin_q <= sin_d;
      cos_q <= cos_d;
    end
  end

  // Always ready once out of reset
  logic busy_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) busy_q <= 1'b1;
    else         busy_q <= 1'b0;
  end
  assign busy = busy_q;

  logic accept;
  assign accept = start && !busy_q;

  // ---------------------------------------------------------------
  // Datapath, one register per stage:
  //   s1 offsets from center, s2 four products, s3 sums,
  //   s4 truncation toward zero, s5 center add and clamp (output).
  // ---------------------------------------------------------------
  logic v1_q, v2_q, v3_q, v4_q, v5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0; v4_q <= 1'b0; v5_q <= 1'b0;
    end else begin
      v1_q <= accept; v2_q <= v1_q; v3_q <= v2_q; v4_q <= v3_q; v5_q <= v4_q;
    end
  end

  // s1
  logic signed [DIFF_W-1:0] dx1_q, dy1_q;
  always_ff @(posedge clk_i) begin
    if (accept) begin
      dx1_q <= DIFF_W'(point_x_i) - DIFF_W'(cx_q);
      dy1_q <= DIFF_W'(point_y_i) - DIFF_W'(cy_q);
    end
  end

  // s2
  logic signed [PROD_W-1:0] xc_d, ys_d, xs_d, yc_d;
  logic signed [PROD_W-1:0] xc2_q, ys2_q, xs2_q, yc2_q;
  assign xc_d = dx1_q * cos_q;
  assign ys_d = dy1_q * sin_q;
  assign xs_d = dx1_q * sin_q;
  assign yc_d = dy1_q * cos_q;

  always_ff @(posedge clk_i) begin
    if (v1_q) begin
      xc2_q <= xc_d; ys2_q <= ys_d; xs2_q <= xs_d; yc2_q <= yc_d;
    end
  end

  // s3
  logic signed [SUM_W-1:0] sx3_q, sy3_q;
  always_ff @(posedge clk_i) begin
    if (v2_q) begin
      sx3_q <= SUM_W'(xc2_q) - SUM_W'(ys2_q);
      sy3_q <= SUM_W'(xs2_q) + SUM_W'(yc2_q);
    end
  end

  // s4: negative sums get 2^F-1 added so the arithmetic shift truncates toward zero
  localparam logic signed [SUM_W-1:0] TRUNC_BIAS = SUM_W'((64'd1 << TRIG_FRAC_BITS) - 64'd1);
  logic signed [SUM_W-1:0] bx, by;
  logic signed [OFF_W-1:0] ox4_q, oy4_q;
  assign bx = sx3_q + (sx3_q[SUM_W-1] ? TRUNC_BIAS : '0);
  assign by = sy3_q + (sy3_q[SUM_W-1] ? TRUNC_BIAS : '0);

  always_ff @(posedge clk_i) begin
    if (v3_q) begin
      ox4_q <= bx[SUM_W-1:TRIG_FRAC_BITS];
      oy4_q <= by[SUM_W-1:TRIG_FRAC_BITS];
    end
  end

  // s5: add center back, clamp to coordinate range
  localparam logic signed [RES_W-1:0] RES_HI = RES_W'(COORD_HI);
  localparam logic signed [RES_W-1:0] RES_LO = RES_W'(COORD_LO);
  logic signed [RES_W-1:0]      rx, ry;
  logic signed [COORD_BITS-1:0] qx, qy;
  logic                         satx, saty;

  always_comb begin
    rx = RES_W'(ox4_q) + RES_W'(cx_q);
    ry = RES_W'(oy4_q) + RES_W'(cy_q);
    satx = 1'b1; saty = 1'b1;
    priority if (rx > RES_HI) qx = COORD_HI;
    else if (rx < RES_LO)     qx = COORD_LO;
    else begin qx = rx[COORD_BITS-1:0]; satx = 1'b0; end
    priority if (ry > RES_HI) qy = COORD_HI;
    else if (ry < RES_LO)     qy = COORD_LO;
    else begin qy = ry[COORD_BITS-1:0]; saty = 1'b0; end
  end

  logic signed [COORD_BITS-1:0] rot_x_q, rot_y_q;
  logic                         sat_q;
  always_ff @(posedge clk_i) begin
    if (v4_q) begin
      rot_x_q <= qx;
      rot_y_q <= qy;
      sat_q   <= satx | saty;
    end
  end

  assign done_o      = v5_q;
  assign rotated_x_o = rot_x_q;
  assign rotated_y_o = rot_y_q;
  assign saturated_o = sat_q;

endmodule

>>> rtl/prc_checker.sv
// Port-level checker for the point rotation block, bound to the top level.
// Depends on prc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module prc_checker (
  input logic                                  clk_i,
  input logic                                  rst_ni,
  input logic                                  start,
  input logic                                  busy,
  input logic                                  done_o,
  input logic signed [prc_pkg::COORD_BITS-1:0] rotated_x_o,
  input logic signed [prc_pkg::COORD_BITS-1:0] rotated_y_o,
  input logic                                  saturated_o
);
  import prc_pkg::*;

  logic x_at_limit, y_at_limit;
  assign x_at_limit = (rotated_x_o == COORD_HI) || (rotated_x_o == COORD_LO);
  assign y_at_limit = (rotated_y_o == COORD_HI) || (rotated_y_o == COORD_LO);

  // every accepted word comes out later with done_o
  `ASSERT_CLK(a_result_follows, (start && !busy) |-> ##5 done_o)
  // no result without an accepted word behind it
  `ASSERT_CLK(a_no_phantom, done_o |-> $past(start && !busy, 5))
  // a clamped result sits on a limit
  `ASSERT_CLK(a_sat_at_limit, (done_o && saturated_o) |-> (x_at_limit || y_at_limit))
  // once ready, the block stays ready
  `ASSERT_NEVER(a_busy_back, $past(!busy) && busy)

endmodule

bind point_rotate_about_center_top prc_checker u_prc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .done_o      (done_o),
  .rotated_x_o (rotated_x_o),
  .rotated_y_o (rotated_y_o),
  .saturated_o (saturated_o)
);

>>> test/point_rotate_about_center_top_test.sv
// Self-checking bench for point_rotate_about_center_top: directed rows, then random phases.
// Each word is checked against a hand-worked result or a local rotation predictor. Depends on prc_pkg and the RTL.
`timescale 1ns / 1ps

module point_rotate_about_center_top_test;

  typedef logic signed [prc_pkg::COORD_BITS-1:0] coord_t;
  typedef logic signed [prc_pkg::ANGLE_BITS-1:0] angle_t;
  typedef logic [prc_pkg::CFG_W-1:0]             cfg_word_t;
  typedef logic [prc_pkg::CFG_IDX_W-1:0]         cfg_idx_t;

  // Index 3 is not decoded by the block; writes there must change nothing.
  localparam cfg_idx_t CFG_SPARE = 2'd3;

  typedef struct packed {
    coord_t x;
    coord_t y;
    logic   sat;
  } rotation_t;

  // One row of the directed table. Rows with typed set carry a hand-worked result.
  typedef struct packed {
    angle_t    angle;
    coord_t    cx;
    coord_t    cy;
    coord_t    px;
    coord_t    py;
    logic      spare;
    logic      typed;
    rotation_t res;
  } vector_t;

  // round(sin(k deg) * 2^16), k = 0..90
  int sine_q16_tab [0:90] = '{
    0, 1144, 2287, 3430, 4572, 5712, 6850, 7987, 9121, 10252,
    11380, 12505, 13626, 14742, 15855, 16962, 18064, 19161, 20252, 21336,
    22415, 23486, 24550, 25607, 26656, 27697, 28729, 29753, 30767, 31772,
    32768, 33754, 34729, 35693, 36647, 37590, 38521, 39441, 40348, 41243,
    42126, 42995, 43852, 44695, 45525, 46341, 47143, 47930, 48703, 49461,
    50203, 50931, 51643, 52339, 53020, 53684, 54332, 54963, 55578, 56175,
    56756, 57319, 57865, 58393, 58903, 59396, 59870, 60326, 60764, 61183,
    61584, 61966, 62328, 62672, 62997, 63303, 63589, 63856, 64104, 64332,
    64540, 64729, 64898, 65048, 65177, 65287, 65376, 65446, 65496, 65526,
    65536
  };

  // Every input has a known value from time zero.
  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      start       = 1'b0;
  coord_t    point_x_i   = '0;
  coord_t    point_y_i   = '0;
  logic      cfg_we_i    = 1'b0;
  cfg_idx_t  cfg_idx_i   = '0;
  cfg_word_t cfg_wdata_i = '0;
  logic      busy;
  logic      done_o;
  coord_t    rotated_x_o;
  coord_t    rotated_y_o;
  logic      saturated_o;

  // Local copy of the register file, kept in step with every write.
  angle_t angle_shadow = '0;
  coord_t cx_shadow    = '0;
  coord_t cy_shadow    = '0;

  rotation_t due_rotations[$];  // results owed by the block, oldest first
  int        err_count  = 0;
  int        result_num = 0;

  point_rotate_about_center_top u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .point_x_i   (point_x_i),
    .point_y_i   (point_y_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .done_o      (done_o),
    .rotated_x_o (rotated_x_o),
    .rotated_y_o (rotated_y_o),
    .saturated_o (saturated_o)
  );

  // 12 ns clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Hard stop, far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("point_rotate_about_center_top_test: errors");
    $finish;
  end

  // Prints one line per mismatch and counts it.
  task automatic log_mismatch(input string what);
    err_count++;
    $display("%0t ns: %s", $time, what);
  endtask

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Table entry scaled to Q1.TRIG_FRAC_BITS; narrowing rounds half up.
  function automatic longint trig_q(input int k);
    longint t;
    int     sh;
    t = longint'(sine_q16_tab[k]);
    if (prc_pkg::TRIG_FRAC_BITS >= 16) return t <<< (prc_pkg::TRIG_FRAC_BITS - 16);
    sh = 16 - prc_pkg::TRIG_FRAC_BITS;
    return (t + (longint'(1) <<< (sh - 1))) >>> sh;
  endfunction

  // Drop the fraction bits, rounding toward zero.
  function automatic longint trunc_frac(input longint v);
    if (v >= 0) return v >>> prc_pkg::TRIG_FRAC_BITS;
    return -((-v) >>> prc_pkg::TRIG_FRAC_BITS);
  endfunction

  function automatic coord_t clamp(input longint v);
    longint hi;
    hi = (longint'(1) <<< (prc_pkg::COORD_BITS - 1)) - 1;
    if (v > hi) return coord_t'(hi);
    if (v < -hi - 1) return coord_t'(-hi - 1);
    return coord_t'(v);
  endfunction

  function automatic rotation_t rotate_about_center(input coord_t px, input coord_t py);
    rotation_t r;
    longint    turn, dx, dy, ox, oy, vx, vy, a, b, sn, cs;
    int        quad, rest;
    // C-style remainder keeps the sign of the register; fold into 0..359
    turn = longint'(angle_shadow) % 360;
    if (turn < 0) turn = turn + 360;
    dx = longint'(px) - longint'(cx_shadow);
    dy = longint'(py) - longint'(cy_shadow);
    if (turn == 0) begin
      ox = dx;
      oy = dy;
    end else if (turn == 90) begin
      ox = -dy;
      oy = dx;
    end else if (turn == 180) begin
      ox = -dx;
      oy = -dy;
    end else if (turn == 270) begin
      ox = dy;
      oy = -dx;
    end else begin
      quad = int'(turn / 90);
      rest = int'(turn % 90);
      a    = trig_q(rest);
      b    = trig_q(90 - rest);
      case (quad)
        0: begin
          sn = a;
          cs = b;
        end
        1: begin
          sn = b;
          cs = -a;
        end
        2: begin
          sn = -a;
          cs = -b;
        end
        default: begin
          sn = -b;
          cs = a;
        end
      endcase
      ox = trunc_frac(dx * cs - dy * sn);
      oy = trunc_frac(dx * sn + dy * cs);
    end
    vx    = ox + longint'(cx_shadow);
    vy    = oy + longint'(cy_shadow);
    r.x   = clamp(vx);
    r.y   = clamp(vy);
    r.sat = (longint'(r.x) != vx) || (longint'(r.y) != vy);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------------

  // One register write; the caller lowers cfg_we_i after the last one.
  task automatic write_reg(input cfg_idx_t idx, input cfg_word_t data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    case (idx)
      prc_pkg::CFG_ANGLE:    angle_shadow = angle_t'(data[prc_pkg::ANGLE_BITS-1:0]);
      prc_pkg::CFG_CENTER_X: cx_shadow = coord_t'(data);
      prc_pkg::CFG_CENTER_Y: cy_shadow = coord_t'(data);
      default: ;
    endcase
  endtask

  // Writes all three registers back to back, optionally preceded by a write to
  // the undecoded index. Angle writes carry junk in the bits above the field.
  task automatic load_config(input angle_t a, input coord_t cx, input coord_t cy,
                             input bit spare);
    cfg_word_t data;
    if (spare) write_reg(CFG_SPARE, cfg_word_t'($urandom));
    data = cfg_word_t'($urandom);
    data[prc_pkg::ANGLE_BITS-1:0] = a;
    write_reg(prc_pkg::CFG_ANGLE, data);
    write_reg(prc_pkg::CFG_CENTER_X, cfg_word_t'(cx));
    write_reg(prc_pkg::CFG_CENTER_Y, cfg_word_t'(cy));
    cfg_we_i <= 1'b0;
  endtask

  // Stop issuing and wait for every owed word, giving up once the caller's limit runs out.
  task automatic drain(input int limit);
    int spins;
    spins = 0;
    start <= 1'b0;
    while (due_rotations.size() != 0 && spins < limit) begin
      @(posedge clk_i);
      spins++;
    end
  endtask

  // Random hold-off before a word. About one word in five or six gets a gap,
  // which puts roughly 23% idle cycles on start.
  task automatic maybe_pause(input bit allowed);
    if (allowed && $urandom_range(0, 99) < 18) begin
      start <= 1'b0;
      repeat (($urandom_range(0, 3) == 0) ? $urandom_range(2, 5) : 1) @(posedge clk_i);
    end
  endtask

  // Present a point and hold it until the block takes it (start high, busy low
  // at an edge). The expectation is queued at the accepting edge, using the
  // registers as they stand; they never change while words are in flight.
  task automatic send_point(input coord_t px, input coord_t py, input bit typed,
                            input rotation_t typed_res);
    start     <= 1'b1;
    point_x_i <= px;
    point_y_i <= py;
    do @(posedge clk_i); while (busy);
    due_rotations.push_back(typed ? typed_res : rotate_about_center(px, py));
  endtask

  // ---------------------------------------------------------------------------
  // Random choices
  // ---------------------------------------------------------------------------

  function automatic angle_t pick_angle();
    case ($urandom_range(0, 5))
      0: begin
        // quarter turns, including aliases beyond one revolution
        case ($urandom_range(0, 7))
          0: return angle_t'(0);
          1: return angle_t'(90);
          2: return angle_t'(180);
          3: return angle_t'(270);
          4: return angle_t'(-90);
          5: return angle_t'(-270);
          6: return angle_t'(-360);
          default: return angle_t'(450);
        endcase
      end
      1: begin
        // register and nominal range limits
        case ($urandom_range(0, 3))
          0: return angle_t'(-512);
          1: return angle_t'(511);
          2: return angle_t'(-359);
          default: return angle_t'(359);
        endcase
      end
      default: return angle_t'($urandom);
    endcase
  endfunction

  function automatic coord_t pick_edge();
    case ($urandom_range(0, 3))
      0: return prc_pkg::COORD_LO;
      1: return prc_pkg::COORD_HI;
      2: return coord_t'(0);
      default: return coord_t'(-1);
    endcase
  endfunction

  function automatic coord_t pick_center();
    if ($urandom_range(0, 3) == 0) return pick_edge();
    return coord_t'($urandom);
  endfunction

  // Points near the center stay in range; far ones exercise clamping.
  function automatic coord_t pick_coord(input int mode, input coord_t c);
    case (mode)
      0: return pick_edge();
      1, 2: return coord_t'(c + coord_t'($urandom_range(0, 2000)) - coord_t'(1000));
      default: return coord_t'($urandom);
    endcase
  endfunction

  function automatic vector_t vec(input angle_t a, input coord_t cx, input coord_t cy,
                                  input coord_t px, input coord_t py, input bit spare,
                                  input bit typed, input coord_t ex, input coord_t ey,
                                  input bit esat);
    vector_t v;
    v.angle   = a;
    v.cx      = cx;
    v.cy      = cy;
    v.px      = px;
    v.py      = py;
    v.spare   = spare;
    v.typed   = typed;
    v.res.x   = ex;
    v.res.y   = ey;
    v.res.sat = esat;
    return v;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking: every done_o cycle is one word, matched to the oldest owed.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : check_results
    rotation_t want;
    if (rst_ni && done_o) begin
      result_num++;
      if (due_rotations.size() == 0) begin
        log_mismatch($sformatf("word %0d: result with nothing owed", result_num));
      end else begin
        want = due_rotations.pop_front();
        if (rotated_x_o !== want.x)
          log_mismatch($sformatf("word %0d: rotated_x %0d, want %0d",
                                 result_num, rotated_x_o, want.x));
        if (rotated_y_o !== want.y)
          log_mismatch($sformatf("word %0d: rotated_y %0d, want %0d",
                                 result_num, rotated_y_o, want.y));
        if (saturated_o !== want.sat)
          log_mismatch($sformatf("word %0d: saturated %b, want %b",
                                 result_num, saturated_o, want.sat));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    vector_t   directed[$];
    vector_t   v;
    rotation_t blank;
    coord_t    px, py;
    int        mode;

    blank = '0;

    //                   angle  cx      cy      px      py   spare typed ex     ey   sat
    // registers still at reset: identity
    directed.push_back(vec(0,    0,      0,      1234,   -567,   0, 1, 1234,   -567,  0));
    directed.push_back(vec(0,    0,      0,      32767,  -32768, 0, 1, 32767,  -32768, 0));
    // identity with extreme center: offsets overflow 16 bits but cancel
    directed.push_back(vec(0,    -32768, 32767,  32767,  -32768, 0, 1, 32767,  -32768, 0));
    // quarter turns are exact
    directed.push_back(vec(90,   0,      0,      100,    200,    0, 1, -200,   100,   0));
    directed.push_back(vec(90,   0,      0,      0,      -32768, 0, 1, 32767,  0,     1));
    directed.push_back(vec(180,  0,      0,      -32768, -32768, 0, 1, 32767,  32767, 1));
    directed.push_back(vec(180,  10,     20,     15,     25,     0, 1, 5,      15,    0));
    directed.push_back(vec(270,  0,      0,      5,      -7,     0, 1, -7,     -5,    0));
    // negative angle turns clockwise: -90 is 270
    directed.push_back(vec(-90,  0,      0,      5,      -7,     0, 1, -7,     -5,    0));
    // 450 folds to 90; the undecoded index is written first and ignored
    directed.push_back(vec(450,  0,      0,      3,      4,      1, 1, -4,     3,     0));
    directed.push_back(vec(-360, 0,      0,      -32768, 32767,  0, 1, -32768, 32767, 0));
    // point on the center stays put at any angle
    directed.push_back(vec(45,   1000,   -1000,  1000,   -1000,  0, 1, 1000,   -1000, 0));
    // register extremes and table-driven angles, predicted
    directed.push_back(vec(511,  0,      0,      32767,  32767,  0, 0, 0, 0, 0));
    directed.push_back(vec(-512, 0,      0,      -32768, 32767,  0, 0, 0, 0, 0));
    directed.push_back(vec(359,  0,      0,      20000,  -20000, 0, 0, 0, 0, 0));
    directed.push_back(vec(-359, 0,      0,      32767,  0,      0, 0, 0, 0, 0));
    directed.push_back(vec(1,    -32768, -32768, 32767,  32767,  0, 0, 0, 0, 0));
    directed.push_back(vec(30,   0,      0,      1000,   0,      0, 0, 0, 0, 0));
    directed.push_back(vec(89,   0,      0,      -32768, -32768, 0, 0, 0, 0, 0));
    directed.push_back(vec(91,   32767,  32767,  -32768, -32768, 0, 0, 0, 0, 0));
    directed.push_back(vec(179,  100,    -100,   3,      -3,     0, 0, 0, 0, 0));
    directed.push_back(vec(181,  100,    -100,   3,      -3,     0, 0, 0, 0, 0));
    directed.push_back(vec(269,  0,      0,      12345,  -1,     0, 0, 0, 0, 0));
    directed.push_back(vec(271,  0,      0,      -1,     -1,     0, 0, 0, 0, 0));
    directed.push_back(vec(-1,   0,      0,      0,      1,      0, 0, 0, 0, 0));

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed rows. Registers change only with the pipe empty.
    foreach (directed[i]) begin
      v = directed[i];
      if (v.spare || v.angle != angle_shadow || v.cx != cx_shadow || v.cy != cy_shadow) begin
        drain(1000);
        load_config(v.angle, v.cx, v.cy, v.spare);
      end
      maybe_pause(1'b1);
      send_point(v.px, v.py, v.typed, v.res);
    end

    // Random phases: a fresh register setting, then 125 words each.
    // Phases 6 and 7 issue back to back with no gaps.
    for (int ph = 0; ph < 14; ph++) begin
      drain(1000);
      load_config(pick_angle(), pick_center(), pick_center(), $urandom_range(0, 2) == 0);
      for (int n = 0; n < 125; n++) begin
        maybe_pause(ph != 6 && ph != 7);
        mode = $urandom_range(0, 5);
        px   = pick_coord(mode, cx_shadow);
        py   = pick_coord(mode, cy_shadow);
        send_point(px, py, 1'b0, blank);
      end
    end

    // Let the last words come out, then a short tail
    // so a stray extra done_o would still be caught.
    drain(200);
    repeat (8) @(posedge clk_i);
    if (due_rotations.size() != 0)
      log_mismatch($sformatf("%0d words never came out", due_rotations.size()));

    if (err_count == 0) begin
      $display("point_rotate_about_center_top_test: clean");
    end else begin
      $display("point_rotate_about_center_top_test: errors");
    end
    $finish;
  end

endmodule
